// ----- hw/rtl/rsc_pkg.sv -----
// Shared types, constants and state encoding of the ROM sector cache tag engine.
`timescale 1ns / 1ps
`default_nettype none

package rsc_pkg;

	// Geometry of the cached region
	localparam int LINES_DEF  = 64;
	localparam int LINE_BYTES = 512;
	localparam int ADDR_BITS  = 23;
	localparam int OFF_BITS   = $clog2(LINE_BYTES);
	localparam int SECT_W     = ADDR_BITS - OFF_BITS;

	// Fixed low region: 0x0000..0x3FFF in 512-byte sectors
	localparam int LOW_LIMIT      = 'h4000;
	localparam int LOW_SECT_BYTES = 512;
	localparam int LOW_OFF_BITS   = $clog2(LOW_SECT_BYTES);
	localparam int LOW_SECTORS    = LOW_LIMIT / LOW_SECT_BYTES;
	localparam int LOW_SEL_W      = $clog2(LOW_SECTORS);

	// Result field widths
	localparam int LINE_IDX_W = 6;
	localparam int BOFF_W     = 9;
	localparam int FILL_W     = 14;

	// Age stamps and the shared compare unit
	localparam int AGE_W = 32;

	// Memory port controls from the sequencer
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic wr_tag;
	} rsc_mem_ctl_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLASS,
		ST_TAG,
		ST_AGE,
		ST_UPDATE,
		ST_RESP
	} rsc_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rsc_cmp.sv -----
// Shared equality and unsigned less-than compare unit.
`timescale 1ns / 1ps
`default_nettype none

module rsc_cmp (
	input  wire logic [rsc_pkg::AGE_W-1:0] a,
	input  wire logic [rsc_pkg::AGE_W-1:0] b,
	output logic                           eq,
	output logic                           lt
);

	// One comparator serves the shortcut, the tag walk and the age walk
	always_comb begin
		eq = (a == b);
		lt = (a < b);
	end

endmodule

`default_nettype wire

// ----- hw/rtl/rsc_store.sv -----
// Line tag and age memories with per-line valid bits.
`timescale 1ns / 1ps
`default_nettype none

module rsc_store #(
	parameter int LINES = rsc_pkg::LINES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire rsc_pkg::rsc_mem_ctl_t       ctl,
	input  wire logic [$clog2(LINES)-1:0]    rd_idx,
	input  wire logic [$clog2(LINES)-1:0]    wr_idx,
	input  wire logic [rsc_pkg::SECT_W-1:0]  wr_tag,
	input  wire logic [rsc_pkg::AGE_W-1:0]   wr_age,
	output logic      [rsc_pkg::SECT_W-1:0]  rd_tag,
	output logic      [rsc_pkg::AGE_W-1:0]   rd_age,
	output logic                             rd_valid
);

	logic [rsc_pkg::SECT_W-1:0] tag_mem [LINES];
	logic [rsc_pkg::AGE_W-1:0]  age_mem [LINES];
	logic [LINES-1:0]           line_valid_q;

	// Valid bits: also stand for the age reset, the core treats an invalid line as age zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_valid_q <= '0;
		end else if (ctl.wr_en && ctl.wr_tag) begin
			line_valid_q[wr_idx] <= 1'b1;
		end
	end

	// Memory write port
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			age_mem[wr_idx] <= wr_age;
			if (ctl.wr_tag) begin
				tag_mem[wr_idx] <= wr_tag;
			end
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_tag   <= tag_mem[rd_idx];
			rd_age   <= age_mem[rd_idx];
			rd_valid <= line_valid_q[rd_idx];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/rom_sector_cache_lru_core.sv -----
// Top level: ROM sector cache tag and LRU replacement sequencer.
// Paths: low region words and shortcut hits go from classify straight to the result;
//   a tag hit ends the tag walk at the matching line; a miss walks all tags, then ages.
// Throughput: one word at a time; the next word is taken once the result sits in
//   the output register. The serial tag walk and age walk over the single read
//   port and the one shared comparator set the cycle count.
// Reset: asynchronous, clears valid bits, access clock, shortcut and low mask.
`timescale 1ns / 1ps
`default_nettype none

module rom_sector_cache_lru_core #(
	parameter int LINES = rsc_pkg::LINES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [rsc_pkg::ADDR_BITS-1:0]   rom_address,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 in_low_region,
	output logic                                 hit,
	output logic      [rsc_pkg::LINE_IDX_W-1:0]  line_index,
	output logic      [rsc_pkg::BOFF_W-1:0]      byte_offset,
	output logic                                 fill_needed,
	output logic      [rsc_pkg::FILL_W-1:0]      fill_sector
);

	localparam int IDX_W = $clog2(LINES);
	localparam int CNT_W = $clog2(LINES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINES - 1);

	rsc_pkg::rsc_state_t state_q, state_d;

	// Word context
	logic [rsc_pkg::ADDR_BITS-1:0] addr_q;
	logic [rsc_pkg::SECT_W-1:0]    sector_q;
	logic [rsc_pkg::BOFF_W-1:0]    offset_q;
	logic                          low_q;
	logic                          hit_q;
	logic [IDX_W-1:0]              line_q;

	// Persistent state
	logic [rsc_pkg::AGE_W-1:0]       clock_q;
	logic [rsc_pkg::SECT_W-1:0]      recent_sector_q;
	logic                            recent_valid_q;
	logic [IDX_W-1:0]                recent_line_q;
	logic [rsc_pkg::LOW_SECTORS-1:0] low_loaded_q;

	// Walk
	logic [CNT_W-1:0]          scan_q;
	logic                      pend_s1;
	logic [IDX_W-1:0]          idx_s1;
	logic [IDX_W-1:0]          best_q;
	logic [rsc_pkg::AGE_W-1:0] best_age_q;

	// Output register
	logic                           out_valid_q;
	logic                           out_low_q;
	logic                           out_hit_q;
	logic [rsc_pkg::LINE_IDX_W-1:0] out_line_q;
	logic [rsc_pkg::BOFF_W-1:0]     out_offset_q;
	logic [rsc_pkg::FILL_W-1:0]     out_sector_q;

	// Store and compare hookup
	rsc_pkg::rsc_mem_ctl_t     mem_ctl;
	logic [rsc_pkg::SECT_W-1:0] rd_tag;
	logic [rsc_pkg::AGE_W-1:0]  rd_age;
	logic                       rd_valid;
	logic [rsc_pkg::AGE_W-1:0]  cmp_a, cmp_b;
	logic                       cmp_eq, cmp_lt;

	logic                       issue;
	logic                       in_acc;
	logic                       out_free;
	logic                       addr_low;
	logic [rsc_pkg::SECT_W-1:0] addr_sector;
	logic [rsc_pkg::LOW_SEL_W-1:0] low_sel;
	logic                       shortcut_hit;
	logic                       tag_hit;
	logic                       walk_last;
	logic [rsc_pkg::AGE_W-1:0]  eff_age;
	logic                       age_take;
	logic [IDX_W-1:0]           victim;

	rsc_store #(.LINES(LINES)) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mem_ctl),
		.rd_idx   (scan_q[IDX_W-1:0]),
		.wr_idx   (line_q),
		.wr_tag   (sector_q),
		.wr_age   (clock_q),
		.rd_tag   (rd_tag),
		.rd_age   (rd_age),
		.rd_valid (rd_valid)
	);

	rsc_cmp u_cmp (
		.a  (cmp_a),
		.b  (cmp_b),
		.eq (cmp_eq),
		.lt (cmp_lt)
	);

	// Address decode
	assign addr_low    = (addr_q < rsc_pkg::ADDR_BITS'(rsc_pkg::LOW_LIMIT));
	assign addr_sector = addr_q[rsc_pkg::ADDR_BITS-1:rsc_pkg::OFF_BITS];
	assign low_sel     = addr_q[rsc_pkg::LOW_OFF_BITS +: rsc_pkg::LOW_SEL_W];

	// Walk status from the compare unit
	assign eff_age      = rd_valid ? rd_age : '0;
	assign shortcut_hit = recent_valid_q && cmp_eq;
	assign tag_hit      = pend_s1 && rd_valid && cmp_eq;
	assign walk_last    = pend_s1 && (idx_s1 == LAST_IDX);
	assign age_take     = pend_s1 && ((idx_s1 == '0) || cmp_lt);
	assign victim       = age_take ? idx_s1 : best_q;

	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rsc_pkg::ST_IDLE: begin
				if (in_valid) state_d = rsc_pkg::ST_CLASS;
			end
			rsc_pkg::ST_CLASS: begin
				if (addr_low || shortcut_hit) state_d = rsc_pkg::ST_RESP;
				else state_d = rsc_pkg::ST_TAG;
			end
			rsc_pkg::ST_TAG: begin
				if (tag_hit) state_d = rsc_pkg::ST_UPDATE;
				else if (walk_last) state_d = rsc_pkg::ST_AGE;
			end
			rsc_pkg::ST_AGE: begin
				if (walk_last) state_d = rsc_pkg::ST_UPDATE;
			end
			rsc_pkg::ST_UPDATE: begin
				state_d = rsc_pkg::ST_RESP;
			end
			rsc_pkg::ST_RESP: begin
				if (out_free) state_d = rsc_pkg::ST_IDLE;
			end
			default: state_d = rsc_pkg::ST_IDLE;
		endcase
	end

	// Control outputs and compare operand select
	always_comb begin
		in_ready = 1'b0;
		issue    = 1'b0;
		mem_ctl  = '0;
		cmp_a    = rsc_pkg::AGE_W'(addr_sector);
		cmp_b    = rsc_pkg::AGE_W'(recent_sector_q);
		unique case (state_q)
			rsc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			rsc_pkg::ST_CLASS: begin
			end
			rsc_pkg::ST_TAG: begin
				issue = (scan_q < CNT_W'(LINES));
				cmp_a = rsc_pkg::AGE_W'(rd_tag);
				cmp_b = rsc_pkg::AGE_W'(sector_q);
			end
			rsc_pkg::ST_AGE: begin
				issue = (scan_q < CNT_W'(LINES));
				cmp_a = eff_age;
				cmp_b = best_age_q;
			end
			rsc_pkg::ST_UPDATE: begin
				mem_ctl.wr_en  = 1'b1;
				mem_ctl.wr_tag = !hit_q;
			end
			rsc_pkg::ST_RESP: begin
			end
			default: begin
			end
		endcase
		mem_ctl.rd_en = issue;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= rsc_pkg::ST_IDLE;
			clock_q         <= '0;
			recent_sector_q <= '0;
			recent_valid_q  <= 1'b0;
			recent_line_q   <= '0;
			low_loaded_q    <= '0;
			scan_q          <= '0;
			pend_s1         <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= issue;
			if (issue) scan_q <= scan_q + CNT_W'(1);

			if (state_q == rsc_pkg::ST_CLASS) begin
				scan_q <= '0;
				if (addr_low) begin
					low_loaded_q[low_sel] <= 1'b1;
				end else if (!shortcut_hit) begin
					clock_q <= clock_q + rsc_pkg::AGE_W'(1);
				end
			end

			// Tag walk done without a hit: restart the counter for the age walk
			if (state_q == rsc_pkg::ST_TAG && !tag_hit && walk_last) scan_q <= '0;

			if (state_q == rsc_pkg::ST_UPDATE) begin
				recent_sector_q <= sector_q;
				recent_valid_q  <= 1'b1;
				recent_line_q   <= line_q;
			end

			if (state_q == rsc_pkg::ST_RESP && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Word context and walk datapath
	always_ff @(posedge clk) begin
		if (in_acc) addr_q <= rom_address;
		if (issue) idx_s1 <= scan_q[IDX_W-1:0];

		unique case (state_q)
			rsc_pkg::ST_CLASS: begin
				low_q <= addr_low;
				if (addr_low) begin
					sector_q <= rsc_pkg::SECT_W'(low_sel);
					offset_q <= rsc_pkg::BOFF_W'(addr_q[rsc_pkg::LOW_OFF_BITS-1:0]);
					hit_q    <= low_loaded_q[low_sel];
					line_q   <= '0;
				end else begin
					sector_q <= addr_sector;
					offset_q <= rsc_pkg::BOFF_W'(addr_q[rsc_pkg::OFF_BITS-1:0]);
					hit_q    <= shortcut_hit;
					line_q   <= recent_line_q;
				end
			end
			rsc_pkg::ST_TAG: begin
				// matching valid line: report a hit there, only its age gets refreshed
				if (tag_hit) begin
					line_q <= idx_s1;
					hit_q  <= 1'b1;
				end
			end
			rsc_pkg::ST_AGE: begin
				if (age_take) begin
					best_q     <= idx_s1;
					best_age_q <= eff_age;
				end
				if (walk_last) line_q <= victim;
			end
			default: begin
			end
		endcase
	end

	// Output register load
	always_ff @(posedge clk) begin
		if (state_q == rsc_pkg::ST_RESP && out_free) begin
			out_low_q    <= low_q;
			out_hit_q    <= hit_q;
			out_line_q   <= rsc_pkg::LINE_IDX_W'(line_q);
			out_offset_q <= offset_q;
			out_sector_q <= rsc_pkg::FILL_W'(sector_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign in_low_region = out_low_q;
	assign hit           = out_hit_q;
	assign line_index    = out_line_q;
	assign byte_offset   = out_offset_q;
	assign fill_needed   = !out_hit_q;
	assign fill_sector   = out_sector_q;

endmodule

`default_nettype wire

// ----- hw/rtl/rsc_checker.sv -----
// Port-level checker for the ROM sector cache tag engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rsc_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            in_valid,
	input wire logic                            in_ready,
	input wire logic                            out_valid,
	input wire logic                            out_ready,
	input wire logic                            in_low_region,
	input wire logic                            hit,
	input wire logic [rsc_pkg::LINE_IDX_W-1:0]  line_index,
	input wire logic                            fill_needed,
	input wire logic [rsc_pkg::FILL_W-1:0]      fill_sector
);

	// A low-region word always reports line zero
	a_low_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_low_region |-> line_index == '0)
		else $error("low region word with nonzero line index");

	// Fill request is exactly the inverse of hit
	a_fill_inv: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hit != fill_needed)
		else $error("hit and fill_needed agree");

	// Low-region sector numbers stay below the region size
	a_low_sector: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_low_region |-> fill_sector[rsc_pkg::FILL_W-1:rsc_pkg::LOW_SEL_W] == '0)
		else $error("low region sector out of range");

	// One word at a time: no accept in the cycle after an accept
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a word is in flight");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(line_index) && $stable(hit))
		else $error("result dropped or changed under stall");

endmodule

bind rom_sector_cache_lru_core rsc_checker u_rsc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.in_low_region (in_low_region),
	.hit           (hit),
	.line_index    (line_index),
	.fill_needed   (fill_needed),
	.fill_sector   (fill_sector)
);

`default_nettype wire
